// ----- sv/r2fft_pkg.sv -----
// ----------------------------------------------------------------------------
// r2fft_pkg
// Types and constants for the radix-2 FFT block: state encoding and the
// quarter-wave sine table used to build twiddle factors.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_WR,
        ST_OUT_RD,
        ST_OUT_HOLD
    } state_t;

    localparam int TW_BITS = 17;

    // round(32767 * sin(2*pi*k/64)), k = 0..16
    function automatic logic signed [TW_BITS-1:0] qsin(input logic [4:0] k);
        logic signed [TW_BITS-1:0] v;
        begin
            unique case (k)
                5'd0:    v = 17'sd0;
                5'd1:    v = 17'sd3212;
                5'd2:    v = 17'sd6393;
                5'd3:    v = 17'sd9512;
                5'd4:    v = 17'sd12539;
                5'd5:    v = 17'sd15446;
                5'd6:    v = 17'sd18204;
                5'd7:    v = 17'sd20787;
                5'd8:    v = 17'sd23170;
                5'd9:    v = 17'sd25329;
                5'd10:   v = 17'sd27245;
                5'd11:   v = 17'sd28898;
                5'd12:   v = 17'sd30273;
                5'd13:   v = 17'sd31356;
                5'd14:   v = 17'sd32137;
                5'd15:   v = 17'sd32609;
                5'd16:   v = 17'sd32767;
                default: v = 17'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- sv/radix2_fft.sv -----
// sequence: the last sample of a frame starts the transform; N/2*log2(N) butterflies
// follow (read a, read b, multiply, write a, write b), then an output read state
// fetches bin 0, valid in the following hold state; throughput: one sample per
// cycle while loading unless cfg_we is high, then each bin takes a read state and
// a hold state until m_ready; reset: synchronous active-low; log2_size returns to 6,
// the load count to zero, the work memory keeps contents and is written before read
// ----------------------------------------------------------------------------
// radix2_fft
// In-place decimation-in-time FFT of real Q1.15 samples, scaled by 1/N, with
// results streamed out in natural bin order.
// ----------------------------------------------------------------------------
module radix2_fft #(
    parameter int POINTS      = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [5:0]                    m_bin_index,
    output logic signed [SAMPLE_BITS-1:0] m_bin_real,
    output logic signed [SAMPLE_BITS-1:0] m_bin_imag,
    output logic                          m_last_bin
);
    import r2fft_pkg::*;

    localparam int AW      = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int MAXL    = AW;
    localparam int PW      = SAMPLE_BITS + TW_BITS + 1;
    localparam int SW      = PW + 2;

    state_t state_reg, state_next;

    logic [2:0]  log2_size_reg;
    logic [AW:0] load_count_reg;
    logic [AW-1:0] j_reg;        // butterfly number within a stage, 0..N/2-1
    logic [2:0]  stage_reg;      // 0..L-1
    logic [AW-1:0] k_reg;        // output bin
    logic        phase_reg;      // butterfly read/write of a or b half

    // effective length
    logic [2:0] eff_l;
    always_comb begin
        eff_l = log2_size_reg;
        if (eff_l == 3'd0) eff_l = 3'd1;
        if (eff_l > 3'(MAXL)) eff_l = 3'(MAXL);
    end

    logic [AW:0] n_pts;
    assign n_pts = (AW+1)'(1) << eff_l;

    // bit reversal of load count over eff_l bits
    logic [AW-1:0] rev_addr;
    always_comb begin
        rev_addr = '0;
        for (int i = 0; i < AW; i++) begin
            if (i < int'(eff_l)) rev_addr[int'(eff_l) - 1 - i] = load_count_reg[i];
        end
    end

    // butterfly addresses
    logic [AW-1:0] half_m;   // 2^stage - 1
    logic [AW-1:0] jl, jh, a_addr, b_addr;
    logic [5:0]    tw_k;
    always_comb begin
        half_m = AW'((AW+1)'(1) << stage_reg) - AW'(1);
        jl     = j_reg & half_m;
        jh     = j_reg & ~half_m;
        a_addr = (jh << 1) | jl;
        b_addr = a_addr | (half_m + AW'(1));
        tw_k   = 6'((32'(jl) * 64) >> (stage_reg + 3'd1));
    end

    // twiddle c, s
    logic [4:0] tk;
    logic signed [TW_BITS-1:0] tw_c, tw_s;
    always_comb begin
        tk = tw_k[4:0];
        if (tk <= 5'd16) begin
            tw_c = qsin(5'd16 - tk);
            tw_s = qsin(tk);
        end else begin
            tw_c = -qsin(tk - 5'd16);
            tw_s = qsin(5'd0 - tk);
        end
    end

    // work memory
    logic [2*SAMPLE_BITS-1:0] mem [POINTS];
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [2*SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    logic [2*SAMPLE_BITS-1:0] a_reg, b_reg;
    logic signed [PW-1:0] tr_reg, ti_reg;
    logic signed [SAMPLE_BITS-1:0] br, bi;
    assign br = b_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign bi = b_reg[SAMPLE_BITS-1:0];

    function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] hi, lo;
        begin
            r  = (v + SW'(32768)) >>> 16;
            hi = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
            lo = -hi - SW'(1);
            if (r > hi) r = hi;
            else if (r < lo) r = lo;
            return r[SAMPLE_BITS-1:0];
        end
    endfunction

    logic signed [SW-1:0] ar_s, ai_s;
    logic signed [SAMPLE_BITS-1:0] a_re, a_im;
    assign a_re = a_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign a_im = a_reg[SAMPLE_BITS-1:0];
    assign ar_s = SW'(a_re) <<< 15;
    assign ai_s = SW'(a_im) <<< 15;

    logic last_bf;
    assign last_bf = (32'(j_reg) == (32'(n_pts) >> 1) - 1) && (stage_reg == eff_l - 3'd1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (s_valid && !cfg_we && load_count_reg + 1'b1 >= n_pts) state_next = ST_BF_RD;
            ST_BF_RD:    if (phase_reg) state_next = ST_BF_MUL;
            ST_BF_MUL:   state_next = ST_BF_WR;
            ST_BF_WR:    if (phase_reg) state_next = last_bf ? ST_OUT_RD : ST_BF_RD;
            ST_OUT_RD:   state_next = ST_OUT_HOLD;
            ST_OUT_HOLD:
                if (m_ready) state_next = (32'(k_reg) == 32'(n_pts) - 1) ? ST_LOAD : ST_OUT_RD;
            default:     state_next = ST_LOAD;
        endcase
    end

    // outputs and memory control
    always_comb begin
        s_ready   = (state_reg == ST_LOAD) && !cfg_we;
        m_valid   = (state_reg == ST_OUT_HOLD);
        mem_we    = 1'b0;
        mem_waddr = rev_addr;
        mem_wdata = {s_sample, {SAMPLE_BITS{1'b0}}};
        mem_raddr = phase_reg ? b_addr : a_addr;
        unique case (state_reg)
            ST_LOAD:   mem_we = s_valid && !cfg_we;
            ST_BF_WR: begin
                mem_we = 1'b1;
                if (!phase_reg) begin
                    mem_waddr = a_addr;
                    mem_wdata = {rnd_sat(ar_s + SW'(tr_reg)), rnd_sat(ai_s + SW'(ti_reg))};
                end else begin
                    mem_waddr = b_addr;
                    mem_wdata = {rnd_sat(ar_s - SW'(tr_reg)), rnd_sat(ai_s - SW'(ti_reg))};
                end
            end
            // keep reading the current bin so a stalled request holds its payload
            ST_OUT_RD, ST_OUT_HOLD: mem_raddr = k_reg;
            default: ;
        endcase
    end

    assign m_bin_index = 6'(k_reg);
    assign m_bin_real  = mem_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign m_bin_imag  = mem_rdata[SAMPLE_BITS-1:0];
    assign m_last_bin  = (32'(k_reg) == 32'(n_pts) - 1);

    logic rd_d_reg;   // read of a during BF_RD phase 0 returns next cycle

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            log2_size_reg  <= 3'd6;
            load_count_reg <= '0;
            j_reg          <= '0;
            stage_reg      <= '0;
            k_reg          <= '0;
            phase_reg      <= 1'b0;
            rd_d_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_d_reg  <= (state_reg == ST_BF_RD) && !phase_reg;
            if (cfg_we) begin
                log2_size_reg  <= cfg_wdata;
                load_count_reg <= '0;
            end else if (state_reg == ST_LOAD && s_valid) begin
                load_count_reg <= (load_count_reg + 1'b1 >= n_pts) ? '0 : load_count_reg + 1'b1;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    j_reg <= '0; stage_reg <= '0; k_reg <= '0; phase_reg <= 1'b0;
                end
                ST_BF_RD:  phase_reg <= ~phase_reg;
                ST_BF_MUL: phase_reg <= 1'b0;
                ST_BF_WR: begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg) begin
                        if (32'(j_reg) == (32'(n_pts) >> 1) - 1) begin
                            j_reg     <= '0;
                            stage_reg <= stage_reg + 3'd1;
                        end else begin
                            j_reg <= j_reg + AW'(1);
                        end
                    end
                end
                ST_OUT_HOLD: if (m_ready) k_reg <= k_reg + AW'(1);
                default: ;
            endcase
        end
    end

    // capture a; b is taken straight from the read data; multiply in ST_BF_MUL
    always_ff @(posedge aclk) begin
        if (rd_d_reg) a_reg <= mem_rdata;
        if (state_reg == ST_BF_MUL) begin
            tr_reg <= PW'(tw_c) * PW'(br) + PW'(tw_s) * PW'(bi);
            ti_reg <= PW'(tw_c) * PW'(bi) - PW'(tw_s) * PW'(br);
        end
    end
    always_comb b_reg = mem_rdata;

`ifndef SYNTH
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_index))
        else $error("bin dropped while stalled");
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_ready)
        else $error("sample taken during transform");
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BF_RD) |-> (stage_reg < eff_l))
        else $error("stage beyond length");
`endif

endmodule
